/* src/wsfr_pkg.sv */
`timescale 1ns / 1ps
package wsfr_pkg;

  localparam int unsigned LengthWidthDef = 64;
  localparam logic [31:0] MaxPayloadRst  = 32'd65536;
  localparam int unsigned QueueDepth     = 2;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_DATA = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    V_OK         = 3'd0,
    V_HEADER     = 3'd1,
    V_CTRL_FRAG  = 3'd2,
    V_CTRL_LONG  = 3'd3,
    V_OVERSIZE   = 3'd4,
    V_CLOSE_CODE = 3'd5,
    V_CLOSE_ONE  = 3'd6,
    V_UTF8       = 3'd7
  } verdict_e;

  localparam logic [3:0] OpText  = 4'd1;
  localparam logic [3:0] OpClose = 4'd8;

  // Byte class produced by the front parser for the back end.
  typedef enum logic [1:0] {
    BC_HDR0  = 2'd0,
    BC_HDR   = 2'd1,
    BC_DATA  = 2'd2
  } bclass_e;

  // One classified byte passing from the front to the back end.
  typedef struct packed {
    bclass_e    cls;
    logic [7:0] data;      // already unmasked for payload bytes
    logic [3:0] opcode;
    logic       fin;
    logic       frame_end;
    logic [6:0] flags;     // header-side faults, one bit per verdict code below V_UTF8, indexed by code
    logic       close_one;
    logic [1:0] pidx;      // 0, 1 or 2+ payload index (saturated)
  } item_t;

  function automatic logic [2:0] rank(input logic [2:0] v);
    logic [2:0] r;
    case (v)
      3'd0:    r = 3'd0;
      3'd1:    r = 3'd7;
      3'd2:    r = 3'd5;
      3'd3:    r = 3'd4;
      3'd4:    r = 3'd3;
      3'd5:    r = 3'd1;
      3'd6:    r = 3'd2;
      default: r = 3'd6;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] merge(input logic [2:0] cur, input logic [2:0] v);
    return (rank(v) > rank(cur)) ? v : cur;
  endfunction

endpackage

/* src/wsfr_front.sv */
`timescale 1ns / 1ps
module wsfr_front #(
  parameter int unsigned LengthWidth = wsfr_pkg::LengthWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [31:0]        max_payload_i,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [7:0]         in_byte_i,
  output logic               push_o,
  input  logic               full_i,
  output wsfr_pkg::item_t    item_o
);

  localparam logic [LengthWidth-1:0] LenMax = '1;

  wsfr_pkg::phase_e       phase_q, phase_d;
  logic [7:0]             hdr_q, hdr_d;
  logic                   masked_q, masked_d;
  logic [3:0]             cnt_q, cnt_d;
  logic [LengthWidth-1:0] len_q, len_d;
  logic [LengthWidth-1:0] left_q, left_d;
  logic [31:0]            key_q, key_d;
  logic [1:0]             mpos_q, mpos_d;
  logic [6:0]             flg_q, flg_d;
  logic [1:0]             pidx_q, pidx_d;

  logic                   take;
  logic                   len_fin;
  logic [LengthWidth-1:0] len_new;
  logic                   end_now;
  logic [7:0]             kbyte;
  logic [3:0]             op_b;

  assign ready_o = !full_i;
  assign take    = valid_i && ready_o;
  assign op_b    = in_byte_i[3:0];

  always_comb begin
    case (mpos_q)
      2'd0:    kbyte = key_q[31:24];
      2'd1:    kbyte = key_q[23:16];
      2'd2:    kbyte = key_q[15:8];
      default: kbyte = key_q[7:0];
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    hdr_d   = hdr_q;
    masked_d = masked_q;
    cnt_d   = cnt_q;
    len_d   = len_q;
    left_d  = left_q;
    key_d   = key_q;
    mpos_d  = mpos_q;
    flg_d   = flg_q;
    pidx_d  = pidx_q;
    len_fin = 1'b0;
    len_new = len_q;
    end_now = 1'b0;
    item_o  = '0;
    item_o.opcode = hdr_q[3:0];
    item_o.fin    = hdr_q[7];
    item_o.cls    = wsfr_pkg::BC_HDR;
    case (phase_q)
      wsfr_pkg::PH_HDR0: begin
        hdr_d  = in_byte_i;
        flg_d  = '0;
        mpos_d = '0;
        pidx_d = '0;
        key_d  = '0;
        item_o.cls    = wsfr_pkg::BC_HDR0;
        item_o.opcode = op_b;
        item_o.fin    = in_byte_i[7];
        if (in_byte_i[6:4] != 3'd0 || (op_b > 4'd2 && op_b < 4'd8) || op_b > 4'd10)
          flg_d[wsfr_pkg::V_HEADER] = 1'b1;
        if (op_b >= 4'd8 && !in_byte_i[7]) flg_d[wsfr_pkg::V_CTRL_FRAG] = 1'b1;
        phase_d = wsfr_pkg::PH_HDR1;
      end
      wsfr_pkg::PH_HDR1: begin
        masked_d = in_byte_i[7];
        if (in_byte_i[6:0] < 7'd126) begin
          len_new = LengthWidth'(in_byte_i[6:0]);
          len_fin = 1'b1;
        end else begin
          len_d   = '0;
          cnt_d   = (in_byte_i[6:0] == 7'd126) ? 4'd2 : 4'd8;
          phase_d = wsfr_pkg::PH_EXT;
        end
      end
      wsfr_pkg::PH_EXT: begin
        if (cnt_q == 4'd8 && in_byte_i[7] && len_q == '0)
          flg_d[wsfr_pkg::V_HEADER] = 1'b1;
        if (len_q[LengthWidth-1 -: 8] != 8'd0) begin
          len_new = LenMax;
          flg_d[wsfr_pkg::V_OVERSIZE] = 1'b1;
        end else begin
          len_new = {len_q[LengthWidth-9:0], in_byte_i};
        end
        len_d = len_new;
        cnt_d = cnt_q - 4'd1;
        if (cnt_q == 4'd1) len_fin = 1'b1;
      end
      wsfr_pkg::PH_KEY: begin
        key_d = {key_q[23:0], in_byte_i};
        cnt_d = cnt_q - 4'd1;
        if (cnt_q == 4'd1) begin
          phase_d = wsfr_pkg::PH_DATA;
          end_now = (left_q == '0);
        end
      end
      default: begin
        item_o.cls  = wsfr_pkg::BC_DATA;
        item_o.data = in_byte_i ^ (masked_q ? kbyte : 8'd0);
        item_o.pidx = pidx_q;
        mpos_d = mpos_q + 2'd1;
        if (pidx_q != 2'd2) pidx_d = pidx_q + 2'd1;
        left_d = left_q - LengthWidth'(1);
        end_now = (left_q == LengthWidth'(1)) || (left_q == '0);
        if (left_q == '0) left_d = '0;
      end
    endcase
    if (len_fin) begin
      len_d  = len_new;
      left_d = len_new;
      if (hdr_q[3] && len_new > LengthWidth'(125)) flg_d[wsfr_pkg::V_CTRL_LONG] = 1'b1;
      if (64'(len_new) > 64'(max_payload_i))
        flg_d[wsfr_pkg::V_OVERSIZE] = 1'b1;
      if (masked_d) begin
        cnt_d   = 4'd4;
        phase_d = wsfr_pkg::PH_KEY;
      end else begin
        phase_d = wsfr_pkg::PH_DATA;
        end_now = (len_new == '0);
      end
    end
    if (end_now) phase_d = wsfr_pkg::PH_HDR0;
    item_o.frame_end = end_now;
    item_o.flags     = flg_d;
    item_o.close_one = (hdr_q[3:0] == wsfr_pkg::OpClose) && (len_d == LengthWidth'(1));
  end

  assign push_o = take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= wsfr_pkg::PH_HDR0;
      hdr_q    <= '0;
      masked_q <= 1'b0;
      cnt_q    <= '0;
      len_q    <= '0;
      left_q   <= '0;
      key_q    <= '0;
      mpos_q   <= '0;
      flg_q    <= '0;
      pidx_q   <= '0;
    end else if (take) begin
      phase_q  <= phase_d;
      hdr_q    <= hdr_d;
      masked_q <= masked_d;
      cnt_q    <= cnt_d;
      len_q    <= len_d;
      left_q   <= left_d;
      key_q    <= key_d;
      mpos_q   <= mpos_d;
      flg_q    <= flg_d;
      pidx_q   <= pidx_d;
    end
  end

`ifndef SYNTHESIS
  a_key_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == wsfr_pkg::PH_KEY |-> cnt_q >= 4'd1 && cnt_q <= 4'd4)
    else $error("key byte count out of range");
  a_ext_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == wsfr_pkg::PH_EXT |-> cnt_q >= 4'd1 && cnt_q <= 4'd8)
    else $error("length byte count out of range");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take |=> $stable(phase_q))
    else $error("phase moved without a transaction");
`endif

endmodule

/* src/wsfr_queue.sv */
`timescale 1ns / 1ps
module wsfr_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  wsfr_pkg::item_t item_i,
  output logic            full_o,
  output logic            empty_o,
  input  logic            pop_i,
  output wsfr_pkg::item_t item_o
);

  wsfr_pkg::item_t mem_q [wsfr_pkg::QueueDepth];
  logic            wp_q, rp_q;
  logic [1:0]      cnt_q;

  assign full_o  = (cnt_q == 2'(wsfr_pkg::QueueDepth));
  assign empty_o = (cnt_q == 2'd0);
  assign item_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

`ifndef SYNTHESIS
  a_no_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into full queue");
  a_no_under: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("pop from empty queue");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(wsfr_pkg::QueueDepth))
    else $error("queue count overflow");
`endif

endmodule

/* src/wsfr_back.sv */
`timescale 1ns / 1ps
module wsfr_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  wsfr_pkg::item_t item_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            kind_o,
  output logic [7:0]      out_byte_o,
  output logic [3:0]      opcode_o,
  output logic            fin_o,
  output logic            frame_end_o,
  output logic [2:0]      verdict_o
);

  logic [1:0]  upend_q, upend_d;
  logic        ubad_q, ubad_d;
  logic        cbad_q, cbad_d;
  logic [7:0]  chi_q, chi_d;
  logic        vld_q;
  logic        load;
  logic        feed;
  logic [15:0] code;
  logic [2:0]  verd;
  logic        ubad_f;

  assign load  = !empty_i && (!vld_q || out_ready_i);
  assign pop_o = load;
  assign code  = {chi_q, item_i.data};

  always_comb begin
    upend_d = upend_q;
    ubad_d  = ubad_q;
    cbad_d  = cbad_q;
    chi_d   = chi_q;
    feed    = 1'b0;
    if (item_i.cls == wsfr_pkg::BC_HDR0) begin
      upend_d = '0;
      ubad_d  = 1'b0;
      cbad_d  = 1'b0;
    end else if (item_i.cls == wsfr_pkg::BC_DATA) begin
      if (item_i.opcode == wsfr_pkg::OpClose) begin
        if (item_i.pidx == 2'd0) chi_d = item_i.data;
        else if (item_i.pidx == 2'd1) begin
          if (code < 16'd1000 || (code >= 16'd1004 && code <= 16'd1006) ||
              (code >= 16'd1012 && code <= 16'd1014) || code == 16'd1100)
            cbad_d = 1'b1;
        end else feed = 1'b1;
      end else if (item_i.opcode == wsfr_pkg::OpText) feed = 1'b1;
    end
    if (feed) begin
      if (upend_q != 2'd0) begin
        if (item_i.data[7:6] == 2'b10) upend_d = upend_q - 2'd1;
        else begin
          ubad_d  = 1'b1;
          upend_d = '0;
        end
      end else if (!item_i.data[7]) begin
        upend_d = '0;
      end else if (item_i.data[7:5] == 3'b110) upend_d = 2'd1;
      else if (item_i.data[7:4] == 4'b1110) upend_d = 2'd2;
      else if (item_i.data[7:3] == 5'b11110) upend_d = 2'd3;
      else ubad_d = 1'b1;
    end
    ubad_f = ubad_d || (upend_d != 2'd0);
    verd = wsfr_pkg::V_OK;
    for (int i = 1; i < 7; i++) begin
      if (item_i.flags[i]) verd = wsfr_pkg::merge(verd, 3'(i));
    end
    if (ubad_f) verd = wsfr_pkg::merge(verd, wsfr_pkg::V_UTF8);
    if (item_i.close_one) verd = wsfr_pkg::merge(verd, wsfr_pkg::V_CLOSE_ONE);
    if (cbad_d) verd = wsfr_pkg::merge(verd, wsfr_pkg::V_CLOSE_CODE);
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_o      <= (item_i.cls == wsfr_pkg::BC_DATA);
      out_byte_o  <= (item_i.cls == wsfr_pkg::BC_DATA) ? item_i.data : 8'd0;
      opcode_o    <= item_i.opcode;
      fin_o       <= item_i.fin;
      frame_end_o <= item_i.frame_end;
      verdict_o   <= item_i.frame_end ? verd : wsfr_pkg::V_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= 1'b0;
      upend_q <= '0;
      ubad_q  <= 1'b0;
      cbad_q  <= 1'b0;
      chi_q   <= '0;
    end else begin
      if (load) vld_q <= 1'b1;
      else if (out_ready_i) vld_q <= 1'b0;
      if (load) begin
        upend_q <= upend_d;
        ubad_q  <= ubad_d;
        cbad_q  <= cbad_d;
        chi_q   <= chi_d;
      end
    end
  end

  assign out_valid_o = vld_q;

`ifndef SYNTHESIS
  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o))
    else $error("stalled result changed");
  a_verd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_end_o |-> verdict_o == wsfr_pkg::V_OK)
    else $error("verdict outside frame end");
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !kind_o |-> out_byte_o == 8'd0)
    else $error("header byte carries data");
`endif

endmodule

/* src/websocket_frame_receiver.sv */
`timescale 1ns / 1ps
// Channel  Direction  Handshake                     Payload
// in       input      in_valid_i / in_ready_o       in_byte_i
// out      output     out_valid_o / out_ready_i     kind, out_byte, opcode, fin, frame_end,
//                                                   verdict
// cfg      input      max_payload_we_i              max_payload_wdata_i
// One byte per clock sustained while out_ready_i stays high; a taken byte is written into
// the queue and later loaded into the output register, from which its result is presented.
// The front parser advances one header/payload step per accepted byte.
// A two-entry queue sits between parser and checker; in_ready_o drops only when it is full.
// Async active-low reset returns to awaiting the first header byte, max_payload = 65536.
module websocket_frame_receiver #(
  parameter int unsigned LengthWidth = wsfr_pkg::LengthWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        max_payload_we_i,
  input  logic [31:0] max_payload_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [7:0]  out_byte_o,
  output logic [3:0]  opcode_o,
  output logic        fin_o,
  output logic        frame_end_o,
  output logic [2:0]  verdict_o
);

  logic [31:0]     max_q;
  logic            push, full, empty, pop;
  wsfr_pkg::item_t f_item, b_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) max_q <= wsfr_pkg::MaxPayloadRst;
    else if (max_payload_we_i) max_q <= max_payload_wdata_i;
  end

  wsfr_front #(.LengthWidth(LengthWidth)) u_front (
    .clk_i, .rst_ni, .max_payload_i(max_q), .valid_i(in_valid_i), .ready_o(in_ready_o),
    .in_byte_i, .push_o(push), .full_i(full), .item_o(f_item)
  );

  wsfr_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .item_i(f_item), .full_o(full), .empty_o(empty),
    .pop_i(pop), .item_o(b_item)
  );

  wsfr_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .item_i(b_item), .pop_o(pop),
    .out_valid_o, .out_ready_i, .kind_o, .out_byte_o, .opcode_o, .fin_o,
    .frame_end_o, .verdict_o
  );

endmodule
